### rtl/ipv4_prefix_table_unit_defines.svh
// assertion helpers for the prefix table
`ifndef IPV4_PREFIX_TABLE_UNIT_DEFINES_SVH
`define IPV4_PREFIX_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define IPT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipv4_prefix_table_unit: check failed");

// next-cycle implication
`define IPT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipv4_prefix_table_unit: check failed");

`endif

### rtl/ipt_pkg.sv
`default_nettype none
package ipt_pkg;

   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 6;
   localparam int RANK_W    = 5;
   localparam int IDX_OUT_W = 7;
   localparam int LEN_SLOTS = 32;

   localparam logic [LEN_W-1:0]  MAX_LEN  = 6'd32;
   localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FULL = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  prefix_len;
   } req_type;

   typedef struct packed {
      logic                 status;
      logic                 hit;
      logic [IDX_OUT_W-1:0] entry_index;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] last;
      logic [RANK_W-1:0] rank;
   } entry_type;

   // network mask for a length of 0..32
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      return ~(ALL_ONES >> len);
   endfunction

endpackage
`default_nettype wire

### rtl/ipt_entry_mem.sv
`default_nettype none
module ipt_entry_mem
   import ipt_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      entry_type     rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/ipt_len_rank.sv
`default_nettype none
module ipt_len_rank
   import ipt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [LEN_W-1:0]  len,
   input  wire logic              alloc,
   output      logic [RANK_W-1:0] rank
);

   localparam int SLOT_W = $clog2(LEN_SLOTS);

   logic [RANK_W-1:0]    rank_ff [LEN_SLOTS];
   logic [LEN_SLOTS-1:0] seen_ff;
   logic [LEN_SLOTS-1:0] seen_in;
   logic [LEN_W-1:0]     fill_ff;
   logic [LEN_W-1:0]     fill_in;
   logic [SLOT_W-1:0]    slot;
   logic                 seen;
   logic                 grab;

   // lengths 1..32 map onto slots 0..31
   assign slot = SLOT_W'(len - LEN_W'(1));
   assign seen = seen_ff[slot];
   assign rank = seen ? rank_ff[slot] : fill_ff[RANK_W-1:0];
   assign grab = alloc && !seen;

   always_comb begin
      seen_in = seen_ff;
      fill_in = fill_ff;
      if (grab) begin
         seen_in[slot] = 1'b1;
         fill_in       = fill_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         fill_ff <= '0;
      end else begin
         seen_ff <= seen_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grab) begin
         rank_ff[slot] <= fill_ff[RANK_W-1:0];
      end
   end

endmodule
`default_nettype wire

### rtl/ipt_ctrl.sv
`default_nettype none
module ipt_ctrl
   import ipt_pkg::*;
#(
   parameter int ENTRIES = 64,
   parameter int CNT_W   = 7,
   parameter int IDX_W   = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire req_type           req_data,
   output      logic              res_valid,
   input  wire logic              res_ready,
   output      rsp_type           res,
   output      logic              mem_wr_en,
   output      logic [IDX_W-1:0]  mem_wr_addr,
   output      entry_type         mem_wr_data,
   output      logic              mem_rd_en,
   output      logic [IDX_W-1:0]  mem_rd_addr,
   input  wire entry_type         mem_rd_data,
   output      logic              rank_alloc,
   output      logic [LEN_W-1:0]  rank_len,
   input  wire logic [RANK_W-1:0] rank_val
);

   localparam int XW = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;
   localparam logic [CNT_W-1:0]     FULL_CNT  = CNT_W'(ENTRIES);
   localparam logic [IDX_OUT_W-1:0] CATCH_IDX = IDX_OUT_W'(ENTRIES);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_SWEEP = 5'b00100,
      S_WRAP  = 5'b01000,
      S_DONE  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type    state_ff, state_in;
   logic              op_ff, op_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] net_ff, net_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              catch_ff, catch_in;
   logic [CNT_W-1:0]  rd_addr_ff, rd_addr_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              cmp_last_ff, cmp_last_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [RANK_W-1:0] best_rank_ff, best_rank_in;
   rsp_type           res_ff, res_in;

   logic [LEN_W-1:0]  req_len;
   logic [ADDR_W-1:0] req_mask;
   logic [XW-1:0]     count_x;
   logic [XW-1:0]     best_x;
   logic              contains;

   assign req_len  = (req_data.prefix_len > MAX_LEN) ? MAX_LEN : req_data.prefix_len;
   assign req_mask = len_mask(req_len);
   assign count_x  = XW'(count_ff);
   assign best_x   = XW'(best_idx_ff);
   assign contains = (net_ff >= mem_rd_data.prefix) && (last_ff <= mem_rd_data.last);

   assign req_stall   = (state_ff != S_IDLE);
   assign res_valid   = (state_ff == S_DONE);
   assign res         = res_ff;
   assign rank_len    = len_ff;
   assign mem_wr_addr = count_ff[IDX_W-1:0];
   assign mem_rd_addr = rd_addr_ff[IDX_W-1:0];

   always_comb begin
      mem_wr_data.prefix = net_ff;
      mem_wr_data.last   = last_ff;
      mem_wr_data.rank   = rank_val;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      len_in       = len_ff;
      net_in       = net_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      catch_in     = catch_ff;
      rd_addr_in   = rd_addr_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_rank_in = best_rank_ff;
      res_in       = res_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      rank_alloc   = 1'b0;
      cmp_idx_in   = rd_addr_ff[IDX_W-1:0];
      cmp_last_in  = (rd_addr_ff == count_ff - CNT_W'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.opcode;
               len_in   = req_len;
               net_in   = req_data.address & req_mask;
               last_in  = (req_data.address & req_mask) | ~req_mask;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (catch_ff) begin
               res_in = '{status: ST_OK, hit: 1'b1, entry_index: CATCH_IDX};
            end else if (op_ff == OP_INSERT) begin
               if (len_ff == '0) begin
                  catch_in = 1'b1;
                  res_in   = '{status: ST_OK, hit: 1'b1, entry_index: CATCH_IDX};
               end else if (count_ff == FULL_CNT) begin
                  res_in = '{status: ST_FULL, hit: 1'b0, entry_index: '0};
               end else begin
                  mem_wr_en  = 1'b1;
                  rank_alloc = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
                  res_in     = '{status: ST_OK, hit: 1'b1,
                                 entry_index: count_x[IDX_OUT_W-1:0]};
               end
            end else if (count_ff == '0) begin
               res_in = '{status: ST_OK, hit: 1'b0, entry_index: '0};
            end else begin
               rd_addr_in = '0;
               found_in   = 1'b0;
               state_in   = S_SWEEP;
            end
         end
         S_SWEEP: begin
            // issue one read per cycle, compare the data in the following cycle
            if (rd_addr_ff != count_ff) begin
               mem_rd_en  = 1'b1;
               rd_addr_in = rd_addr_ff + CNT_W'(1);
            end
            if (cmp_vld_ff) begin
               // ties go to the newer entry
               if (contains && (!found_ff || (mem_rd_data.rank <= best_rank_ff))) begin
                  found_in     = 1'b1;
                  best_idx_in  = cmp_idx_ff;
                  best_rank_in = mem_rd_data.rank;
               end
               if (cmp_last_ff) begin
                  state_in = S_WRAP;
               end
            end
         end
         S_WRAP: begin
            state_in = S_DONE;
            if (found_ff) begin
               res_in = '{status: ST_OK, hit: 1'b1, entry_index: best_x[IDX_OUT_W-1:0]};
            end else begin
               res_in = '{status: ST_OK, hit: 1'b0, entry_index: '0};
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      cmp_vld_in = mem_rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         catch_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         catch_ff   <= catch_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      len_ff       <= len_in;
      net_ff       <= net_in;
      last_ff      <= last_in;
      rd_addr_ff   <= rd_addr_in;
      cmp_last_ff  <= cmp_last_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_rank_ff <= best_rank_in;
      res_ff       <= res_in;
   end

endmodule
`default_nettype wire

### rtl/ipv4_prefix_table_unit.sv
// IPv4 prefix table: stores network prefixes and answers containment lookups.
// Request channel (req_*): one beat carries an opcode, an address and a
// prefix length. Insert masks the address and stores it; a /0 insert sets
// the catch-all entry. Lookup returns the stored prefix that contains the
// query network, the earliest-seen length winning and the newest entry a tie.
// Response channel (rsp_*): exactly one beat per request beat, in order.
// Flow: an insert, a lookup on an empty table, or any request once the
// catch-all is set passes from the execute state straight to the done state;
// a lookup over stored entries goes through the sweep and wrap states first:
// the sweep reads one entry per cycle from the entry memory. The next beat is
// taken only once the block is back in idle after handing on its response.
// A response waiting under rsp_stall sits in the output register; the block
// keeps working on the next request and holds its result until the slot frees.
// Reset (synchronous) empties the table, the length ranks and the catch-all
// at once; no clearing pass is needed.
`default_nettype none
`include "ipv4_prefix_table_unit_defines.svh"
module ipv4_prefix_table_unit
   import ipt_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic              res_valid;
   logic              res_ready;
   rsp_type           res;
   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   entry_type         mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   entry_type         mem_rd_data;
   logic              rank_alloc;
   logic [LEN_W-1:0]  rank_len;
   logic [RANK_W-1:0] rank_val;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   ipt_ctrl #(
      .ENTRIES (ENTRIES),
      .CNT_W   (CNT_W),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rank_alloc  (rank_alloc),
      .rank_len    (rank_len),
      .rank_val    (rank_val)
   );

   ipt_entry_mem #(
      .DEPTH (ENTRIES),
      .AW    (IDX_W)
   ) u_entry_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ipt_len_rank u_len_rank (
      .clock (clock),
      .reset (reset),
      .len   (rank_len),
      .alloc (rank_alloc),
      .rank  (rank_val)
   );

   // output register: free when empty or being taken this cycle
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `IPT_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   `IPT_ASSERT_IMP(a_full_no_hit, clock, reset, rsp_valid, !(rsp_data.status && rsp_data.hit))
   `IPT_ASSERT_NXT(a_result_loaded, clock, reset, res_valid && res_ready, rsp_valid && (rsp_data == $past(res)))

endmodule
`default_nettype wire

### bench/tb_top.sv
`default_nettype none
module tb_top;
   import ipt_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int LEN_LIMIT   = 32;

   typedef struct {
      req_type beat;
      bit      pinned;
      rsp_type answer;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // shadow of the prefix table
   logic [31:0] tbl_net   [TABLE_DEPTH];
   logic [5:0]  tbl_len   [TABLE_DEPTH];
   logic [4:0]  tbl_rank  [TABLE_DEPTH];
   logic [5:0]  len_order [LEN_LIMIT];
   int          tbl_count;
   int          len_count;
   bit          default_route;

   rsp_type      answer_q[$];
   plan_row_type opening[$];
   plan_row_type closing[$];
   rsp_type      want_rsp;
   int           failures;
   int           rsps_seen;
   int           burst_left;

   ipv4_prefix_table_unit #(.ENTRIES(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
      if (plen == 6'd0) return 32'h0;
      return 32'hFFFF_FFFF << (32 - int'(plen));
   endfunction

   // result of one request; updates the shadow table like the block does
   function automatic rsp_type apply_request(input req_type beat);
      rsp_type     r;
      logic [5:0]  plen;
      logic [31:0] m, net, last, top;
      int          rank, best_idx;
      logic [4:0]  best_rank;
      bit          found;
      plen = (beat.prefix_len > 6'd32) ? 6'd32 : beat.prefix_len;
      m    = prefix_mask(plen);
      net  = beat.address & m;
      last = net | ~m;
      r.status      = ST_OK;
      r.hit         = 1'b0;
      r.entry_index = '0;
      if (default_route) begin
         r.hit         = 1'b1;
         r.entry_index = 7'(TABLE_DEPTH);
      end else if (beat.opcode == OP_INSERT) begin
         if (plen == 6'd0) begin
            default_route = 1'b1;
            r.hit         = 1'b1;
            r.entry_index = 7'(TABLE_DEPTH);
         end else if (tbl_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            rank = len_count;
            for (int i = 0; i < len_count; i++)
               if (rank == len_count && len_order[i] == plen) rank = i;
            if (rank == len_count && len_count < LEN_LIMIT) begin
               len_order[len_count] = plen;
               len_count++;
            end
            tbl_net[tbl_count]  = net;
            tbl_len[tbl_count]  = plen;
            tbl_rank[tbl_count] = rank[4:0];
            r.hit               = 1'b1;
            r.entry_index       = 7'(tbl_count);
            tbl_count++;
         end
      end else begin
         found     = 1'b0;
         best_idx  = 0;
         best_rank = '0;
         for (int i = 0; i < tbl_count; i++) begin
            top = tbl_net[i] | ~prefix_mask(tbl_len[i]);
            // earliest-seen length wins, newest entry wins a tie
            if (net >= tbl_net[i] && last <= top && (!found || tbl_rank[i] <= best_rank)) begin
               found     = 1'b1;
               best_rank = tbl_rank[i];
               best_idx  = i;
            end
         end
         if (found) begin
            r.hit         = 1'b1;
            r.entry_index = 7'(best_idx);
         end
      end
      return r;
   endfunction

   function automatic req_type make_req(input logic op, input logic [31:0] addr,
                                        input logic [5:0] plen);
      req_type r;
      r.opcode     = op;
      r.address    = addr;
      r.prefix_len = plen;
      return r;
   endfunction

   function automatic plan_row_type open_row(input logic op, input logic [31:0] addr,
                                             input logic [5:0] plen);
      plan_row_type p;
      p.beat   = make_req(op, addr, plen);
      p.pinned = 1'b0;
      p.answer = '0;
      return p;
   endfunction

   function automatic plan_row_type pinned_row(input logic op, input logic [31:0] addr,
                                               input logic [5:0] plen, input logic st,
                                               input logic hit, input int idx);
      plan_row_type p;
      p.beat               = make_req(op, addr, plen);
      p.pinned             = 1'b1;
      p.answer.status      = st;
      p.answer.hit         = hit;
      p.answer.entry_index = 7'(idx);
      return p;
   endfunction

   // mostly well-formed traffic: queries aimed at stored prefixes, inserts on
   // a few common lengths so ranks and ties repeat
   function automatic req_type draw_request();
      req_type    r;
      int         pick, k;
      logic [5:0] plen;
      r.opcode     = OP_LOOKUP;
      r.address    = $urandom();
      r.prefix_len = 6'($urandom_range(0, 63));
      pick         = $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0) begin
         r.opcode = OP_INSERT;
         if (pick < 6) begin
            case ($urandom_range(0, 4))
               0:       plen = 6'd8;
               1:       plen = 6'd16;
               2:       plen = 6'd24;
               3:       plen = 6'd20;
               default: plen = 6'd32;
            endcase
         end else begin
            plen = 6'($urandom_range(1, 63));
         end
         if (tbl_count > 0 && pick < 4) begin
            k         = $urandom_range(0, tbl_count - 1);
            r.address = tbl_net[k] | ($urandom() >> $urandom_range(1, 31));
         end
         r.prefix_len = plen;
      end else if (tbl_count > 0 && pick < 7) begin
         k = $urandom_range(0, tbl_count - 1);
         if (pick < 5)       plen = 6'($urandom_range(tbl_len[k], 32));
         else if (pick == 5) plen = 6'($urandom_range(33, 63));
         else                plen = 6'($urandom_range(0, tbl_len[k]));
         r.address    = tbl_net[k] | ($urandom() & ~prefix_mask(tbl_len[k]));
         r.prefix_len = plen;
      end
      return r;
   endfunction

   task automatic offer(input req_type beat, input bit pinned, input rsp_type answer);
      rsp_type predicted;
      int      gap;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predicted = apply_request(beat);
      answer_q.push_back(pinned ? answer : predicted);
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // hold the request side until every outstanding answer is back
   task automatic settle();
      req_valid <= 1'b0;
      wait (answer_q.size() == 0);
      @(negedge clock);
   endtask

   task automatic log_failure(input string what, input rsp_type want, input rsp_type got);
      failures++;
      if (failures <= 10)
         $display("%s: expected status=%0d hit=%0d index=%0d, got status=%0d hit=%0d index=%0d",
                  what, want.status, want.hit, want.entry_index,
                  got.status, got.hit, got.entry_index);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsps_seen++;
         if (answer_q.size() == 0) begin
            log_failure("response beat with nothing outstanding", '0, rsp_data);
         end else begin
            want_rsp = answer_q.pop_front();
            if (rsp_data.status !== want_rsp.status || rsp_data.hit !== want_rsp.hit ||
                rsp_data.entry_index !== want_rsp.entry_index)
               log_failure("response mismatch", want_rsp, rsp_data);
         end
      end
   end

   // receiver: stall pattern of its own plus one long hold-off
   initial begin
      int mode, span;
      bit held_off;
      rsp_stall = 1'b0;
      held_off  = 1'b0;
      @(negedge clock);
      forever begin
         if (!held_off && rsps_seen >= 60) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 60);
         repeat (span) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               default: rsp_stall <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;

      opening.push_back(pinned_row(OP_LOOKUP, 32'h0A00_0001, 6'd32, ST_OK, 1'b0, 0));
      opening.push_back(pinned_row(OP_LOOKUP, 32'h0000_0000, 6'd0,  ST_OK, 1'b0, 0));
      opening.push_back(pinned_row(OP_INSERT, 32'hFFFF_FFFF, 6'd32, ST_OK, 1'b1, 0));
      opening.push_back(pinned_row(OP_INSERT, 32'hFFFF_FFFF, 6'd1,  ST_OK, 1'b1, 1));
      opening.push_back(open_row(OP_INSERT, 32'hC0A8_0123, 6'd24));
      // lengths above 32 act as a host route
      opening.push_back(pinned_row(OP_INSERT, 32'h0A0B_0C0D, 6'd63, ST_OK, 1'b1, 3));
      opening.push_back(pinned_row(OP_INSERT, 32'h0A0B_0C0D, 6'd33, ST_OK, 1'b1, 4));
      opening.push_back(open_row(OP_INSERT, 32'h0A12_3456, 6'd8));
      opening.push_back(open_row(OP_INSERT, 32'hC0A8_FFFF, 6'd16));
      opening.push_back(open_row(OP_INSERT, 32'h0A0B_FFFF, 6'd24));
      opening.push_back(open_row(OP_LOOKUP, 32'h0A0B_0C0D, 6'd32));
      opening.push_back(open_row(OP_LOOKUP, 32'hC0A8_01FF, 6'd24));
      opening.push_back(open_row(OP_LOOKUP, 32'hFFFF_FFFF, 6'd32));
      opening.push_back(open_row(OP_LOOKUP, 32'h0000_0000, 6'd32));
      opening.push_back(open_row(OP_LOOKUP, 32'h8000_0000, 6'd1));
      opening.push_back(open_row(OP_LOOKUP, 32'h0A00_0000, 6'd7));
      opening.push_back(open_row(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63));
      opening.push_back(open_row(OP_LOOKUP, 32'h7FFF_FFFF, 6'd32));
      opening.push_back(open_row(OP_INSERT, 32'h7FFF_FFFF, 6'd1));
      opening.push_back(open_row(OP_LOOKUP, 32'h1234_5678, 6'd20));
      opening.push_back(open_row(OP_LOOKUP, 32'h0A0B_0C00, 6'd24));

      // run once the table is full
      closing.push_back(pinned_row(OP_INSERT, 32'h0102_0304, 6'd32, ST_FULL, 1'b0, 0));
      closing.push_back(open_row(OP_LOOKUP, 32'h0A0B_0C0D, 6'd32));
      closing.push_back(pinned_row(OP_INSERT, 32'hDEAD_BEEF, 6'd0,  ST_OK, 1'b1, TABLE_DEPTH));
      closing.push_back(pinned_row(OP_INSERT, 32'h0102_0304, 6'd24, ST_OK, 1'b1, TABLE_DEPTH));
      closing.push_back(pinned_row(OP_LOOKUP, 32'h0102_0304, 6'd32, ST_OK, 1'b1, TABLE_DEPTH));
      closing.push_back(pinned_row(OP_LOOKUP, 32'h0000_0000, 6'd0,  ST_OK, 1'b1, TABLE_DEPTH));
      closing.push_back(pinned_row(OP_INSERT, 32'h0000_0000, 6'd0,  ST_OK, 1'b1, TABLE_DEPTH));

      burst_left = 4;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening[i]) offer(opening[i].beat, opening[i].pinned, opening[i].answer);
      settle();
      repeat (700) offer(draw_request(), 1'b0, '0);
      while (tbl_count < TABLE_DEPTH)
         offer(make_req(OP_INSERT, $urandom(), 6'($urandom_range(1, 32))), 1'b0, '0);
      settle();
      foreach (closing[i]) offer(closing[i].beat, closing[i].pinned, closing[i].answer);
      req_valid <= 1'b0;

      wait (answer_q.size() == 0);
      repeat (100) @(posedge clock);
      if (failures == 0)
         $display("ipv4_prefix_table_unit verification clean");
      else
         $display("ipv4_prefix_table_unit verification failed");
      $finish;
   end

   initial begin
      #(12 * 600000);
      $display("ipv4_prefix_table_unit verification failed");
      $finish;
   end

endmodule
`default_nettype wire
